>>> hw/rtl/php_pkg.sv
// Shared types and constants of the PES header parser.
package php_pkg;

  // Kind of result handed out on the result channel.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_TS      = 2'd1,
    KIND_ERROR   = 2'd2
  } result_kind_e;

  // Error codes carried with an error result.
  typedef enum logic [1:0] {
    ERR_CONTINUITY = 2'd0,
    ERR_START_CODE = 2'd1,
    ERR_STREAM_ID  = 2'd2,
    ERR_BAD_HEADER = 2'd3
  } err_code_e;

  // Start code prefix bytes and stream id ranges.
  localparam logic [7:0] SC_ZERO      = 8'h00;
  localparam logic [7:0] SC_ONE       = 8'h01;
  localparam logic [7:0] SID_PRIV1    = 8'hBD;
  localparam logic [7:0] SID_AUDIO_LO = 8'hC0;
  localparam logic [7:0] SID_AUDIO_HI = 8'hDF;
  localparam logic [7:0] SID_VIDEO_LO = 8'hE0;
  localparam logic [7:0] SID_VIDEO_HI = 8'hEF;
  localparam logic [1:0] MARKER_BITS  = 2'b10;

  // Byte positions inside the fixed part of the header.
  localparam logic [7:0] POS_START_LAST = 8'd2;
  localparam logic [7:0] POS_STREAM_ID  = 8'd3;
  localparam logic [7:0] POS_MARKER     = 8'd6;
  localparam logic [7:0] POS_FLAGS      = 8'd7;
  localparam logic [7:0] POS_HDR_LEN    = 8'd8;
  localparam logic [7:0] FIXED_HDR_LEN  = 8'd9;

  // Header extension limits for the timestamp fields.
  localparam logic [7:0] PTS_MIN_EXT = 8'd4;
  localparam logic [7:0] DTS_MIN_EXT = 8'd9;
  localparam logic [7:0] TS_BYTES    = 8'd5;
  localparam logic [7:0] POS_MAX     = 8'hFF;

  localparam int unsigned TS_W = 33;

  // One work record passed from the front to the back through the queue.
  typedef struct packed {
    logic         emit;      // a result leaves with this record
    result_kind_e kind;
    logic [7:0]   data;
    err_code_e    err;
    logic         eop;
    logic         pts_en;    // shift data into the PTS accumulator
    logic         dts_en;    // shift data into the DTS accumulator
    logic [2:0]   step;      // byte index inside the 5-byte timestamp field
    logic         dts_copy;  // DTS is absent, report PTS in its place
  } php_op_t;

endpackage

>>> hw/rtl/php_in_if.sv
// Input channel carrying transport payload bytes and their packet context.
interface php_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic       unit_start;
  logic [3:0] counter_value;
  logic [7:0] packet_length;

  modport source (
    output valid, data_byte, first_byte, last_byte, unit_start, counter_value,
           packet_length,
    input  ready
  );
  modport sink (
    input  valid, data_byte, first_byte, last_byte, unit_start, counter_value,
           packet_length,
    output ready
  );
endinterface

>>> hw/rtl/php_out_if.sv
// Result channel carrying payload bytes, timestamps and error codes.
interface php_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_out;
  logic [32:0] pts_value;
  logic [32:0] dts_value;
  logic [1:0]  error_code;
  logic        end_of_packet;

  modport source (
    output valid, result_kind, payload_out, pts_value, dts_value, error_code,
           end_of_packet,
    input  ready
  );
  modport sink (
    input  valid, result_kind, payload_out, pts_value, dts_value, error_code,
           end_of_packet,
    output ready
  );
endinterface

>>> hw/rtl/pes_header_parser_unit.sv
// Top level of the PES header parser: front end, work queue and back end.
//
//   Channel   Direction  Handshake        Carries
//   in_i      sink       valid / ready    one transport payload byte with context
//   out_o     source     valid / ready    one payload byte, timestamp pair or error
//   cfg       sink       cfg_we_i only    stream_kind selection
//
// One byte is accepted every cycle while the queue is not full; a result is held
// first in the queue and then in the output register. The front end updates its
// packet state in the cycle of the transfer.
// Reset clears all control state, empties the queue and drops any pending result.
// in_i.ready falls only when the queue holds QUEUE_DEPTH records, which happens
// when out_o stalls.
module pes_header_parser_unit import php_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  php_in_if.sink    in_i,
  php_out_if.source out_o
);

  // Stream kind: low selects video stream ids, high selects audio and private 1.
  logic    stream_kind_q;
  logic    push, full, pop, empty;
  php_op_t op_push, op_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_kind_q <= 1'b0;
    end else if (cfg_we_i) begin
      stream_kind_q <= cfg_wdata_i;
    end
  end

  // The front end decides for every byte what the back end must do with it.
  php_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stream_kind_i (stream_kind_q),
    .in_i          (in_i),
    .full_i        (full),
    .push_o        (push),
    .op_o          (op_push)
  );

  // Bytes that cause nothing never enter the queue.
  php_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_push),
    .full_o  (full),
    .pop_i   (pop),
    .op_o    (op_head),
    .empty_o (empty)
  );

  // The back end assembles timestamps and holds the result until it is taken.
  php_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op_head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> hw/rtl/php_front.sv
// Front end: tracks packet and header position and classifies each byte.
module php_front import php_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      stream_kind_i,
  php_in_if.sink    in_i,
  input  logic      full_i,
  output logic      push_o,
  output php_op_t   op_o
);

  logic       seen_q, seen_d;
  logic [3:0] last_cnt_q, last_cnt_d;
  logic [7:0] pos_q, pos_d;
  logic       drop_q, drop_d;
  logic       hdr_q, hdr_d;
  logic [1:0] flags_q, flags_d;
  logic [7:0] ext_q, ext_d;

  logic       accept;
  logic       stop;
  logic       err_v;
  err_code_e  err_c;
  logic       ts_emit;
  logic       has_pts;
  logic       has_dts;
  logic       sid_ok;
  logic [7:0] k;
  logic [7:0] k_dts;
  logic [7:0] b;
  php_op_t    op;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = !full_i;
  assign b          = in_i.data_byte;

  // Flags and header length are settled by byte 8, so the stored values hold
  // for every byte of the header extension.
  assign has_pts = flags_q[1] && (ext_q > PTS_MIN_EXT);
  assign has_dts = (flags_q == 2'b11) && (ext_q > DTS_MIN_EXT);

  always_comb begin
    if (stream_kind_i) begin
      sid_ok = (b == SID_PRIV1) || ((b >= SID_AUDIO_LO) && (b <= SID_AUDIO_HI));
    end else begin
      sid_ok = (b >= SID_VIDEO_LO) && (b <= SID_VIDEO_HI);
    end
  end

  always_comb begin
    seen_d     = seen_q;
    last_cnt_d = last_cnt_q;
    pos_d      = pos_q;
    drop_d     = drop_q;
    hdr_d      = hdr_q;
    flags_d    = flags_q;
    ext_d      = ext_q;
    stop       = 1'b0;
    err_v      = 1'b0;
    err_c      = ERR_CONTINUITY;
    ts_emit    = 1'b0;
    k          = '0;
    k_dts      = '0;
    op         = '0;
    op.kind    = KIND_PAYLOAD;
    op.err     = ERR_CONTINUITY;
    op.data    = b;
    op.eop     = in_i.last_byte;

    if (in_i.first_byte) begin
      pos_d  = '0;
      drop_d = 1'b0;
      hdr_d  = 1'b0;
      if (seen_q && (in_i.counter_value != (last_cnt_q + 4'd1))) begin
        drop_d  = 1'b1;
        stop    = 1'b1;
        op.emit = 1'b1;
        op.kind = KIND_ERROR;
        op.err  = ERR_CONTINUITY;
      end else if (in_i.unit_start && (in_i.packet_length > FIXED_HDR_LEN)) begin
        hdr_d   = 1'b1;
        flags_d = '0;
        ext_d   = '0;
      end else begin
        seen_d     = 1'b1;
        last_cnt_d = in_i.counter_value;
      end
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 8'd1;
    end

    if (!stop && !drop_d) begin
      if (!hdr_d) begin
        op.emit = 1'b1;
        op.kind = KIND_PAYLOAD;
      end else begin
        priority if (pos_d < POS_START_LAST) begin
          if (b != SC_ZERO) begin
            err_v = 1'b1;
            err_c = ERR_START_CODE;
          end
        end else if (pos_d == POS_START_LAST) begin
          if (b != SC_ONE) begin
            err_v = 1'b1;
            err_c = ERR_START_CODE;
          end
        end else if (pos_d == POS_STREAM_ID) begin
          if (!sid_ok) begin
            err_v = 1'b1;
            err_c = ERR_STREAM_ID;
          end
        end else if (pos_d == POS_MARKER) begin
          if (b[7:6] != MARKER_BITS) begin
            err_v = 1'b1;
            err_c = ERR_BAD_HEADER;
          end
        end else if (pos_d == POS_FLAGS) begin
          flags_d = b[7:6];
        end else if (pos_d == POS_HDR_LEN) begin
          ext_d = b;
          if (({1'b0, b} + {1'b0, FIXED_HDR_LEN}) > {1'b0, in_i.packet_length}) begin
            err_v = 1'b1;
            err_c = ERR_BAD_HEADER;
          end else begin
            seen_d     = 1'b1;
            last_cnt_d = in_i.counter_value;
            if (b == 8'd0) begin
              hdr_d = 1'b0;
            end
          end
        end else if (pos_d > POS_HDR_LEN) begin
          k     = pos_d - FIXED_HDR_LEN;
          k_dts = k - TS_BYTES;
          if (has_pts && (k < TS_BYTES)) begin
            op.pts_en = 1'b1;
            op.step   = k[2:0];
          end
          if (has_dts && (k >= TS_BYTES) && (k_dts < TS_BYTES)) begin
            op.dts_en = 1'b1;
            op.step   = k_dts[2:0];
          end
          if (({1'b0, k} + 9'd1) >= {1'b0, ext_d}) begin
            hdr_d = 1'b0;
            if (has_pts) begin
              ts_emit     = 1'b1;
              op.dts_copy = !has_dts;
            end
          end
        end else begin
          // Bytes 4 and 5 carry the packet length and are not checked.
          err_v = 1'b0;
        end

        if (err_v) begin
          drop_d  = 1'b1;
          hdr_d   = 1'b0;
          op.emit = 1'b1;
          op.kind = KIND_ERROR;
          op.err  = err_c;
        end else if (ts_emit) begin
          op.emit = 1'b1;
          op.kind = KIND_TS;
        end else if (in_i.last_byte && hdr_d) begin
          // The packet ended inside its header.
          drop_d  = 1'b1;
          hdr_d   = 1'b0;
          op.emit = 1'b1;
          op.kind = KIND_ERROR;
          op.err  = ERR_BAD_HEADER;
        end
      end
    end
  end

  assign op_o   = op;
  assign push_o = accept && (op.emit || op.pts_en || op.dts_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_cnt_q <= '0;
      pos_q      <= '0;
      drop_q     <= 1'b0;
      hdr_q      <= 1'b0;
      flags_q    <= '0;
      ext_q      <= '0;
    end else if (accept) begin
      seen_q     <= seen_d;
      last_cnt_q <= last_cnt_d;
      pos_q      <= pos_d;
      drop_q     <= drop_d;
      hdr_q      <= hdr_d;
      flags_q    <= flags_d;
      ext_q      <= ext_d;
    end
  end

endmodule

>>> hw/rtl/php_queue.sv
// Small first-in first-out queue of work records between front and back.
module php_queue import php_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  php_op_t op_i,
  output logic    full_o,
  input  logic    pop_i,
  output php_op_t op_o,
  output logic    empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  php_op_t            mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/php_back.sv
// Back end: builds the timestamps and drives the registered result channel.
module php_back import php_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  php_op_t   op_i,
  input  logic      empty_i,
  output logic      pop_o,
  php_out_if.source out_o
);

  logic [TS_W-1:0] pts_q, dts_q;
  logic [TS_W-1:0] pts_n, dts_n;
  logic            out_v_q;
  result_kind_e    kind_q;
  logic [7:0]      pay_q;
  logic [TS_W-1:0] pts_out_q, dts_out_q;
  err_code_e       err_q;
  logic            eop_q;
  logic            load;

  // One byte of the 5-byte timestamp field: 3 bits, then 8 and 7 twice.
  function automatic logic [TS_W-1:0] ts_step(input logic [TS_W-1:0] acc,
                                              input logic [2:0] k,
                                              input logic [7:0] b);
    logic [TS_W-1:0] r;
    unique case (k)
      3'd0:       r = {30'd0, b[3:1]};
      3'd1, 3'd3: r = {acc[TS_W-9:0], b};
      3'd2, 3'd4: r = {acc[TS_W-8:0], b[7:1]};
      default:    r = acc;
    endcase
    return r;
  endfunction

  assign pop_o = !empty_i && (!op_i.emit || !out_v_q || out_o.ready);
  assign load  = pop_o && op_i.emit;
  assign pts_n = op_i.pts_en ? ts_step(pts_q, op_i.step, op_i.data) : pts_q;
  assign dts_n = op_i.dts_en ? ts_step(dts_q, op_i.step, op_i.data) : dts_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pts_q <= pts_n;
      dts_q <= dts_n;
    end
    if (load) begin
      kind_q    <= op_i.kind;
      pay_q     <= (op_i.kind == KIND_PAYLOAD) ? op_i.data : 8'd0;
      pts_out_q <= (op_i.kind == KIND_TS) ? pts_n : '0;
      dts_out_q <= (op_i.kind == KIND_TS) ? (op_i.dts_copy ? pts_n : dts_n) : '0;
      err_q     <= (op_i.kind == KIND_ERROR) ? op_i.err : ERR_CONTINUITY;
      eop_q     <= op_i.eop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.result_kind   = kind_q;
  assign out_o.payload_out   = pay_q;
  assign out_o.pts_value     = pts_out_q;
  assign out_o.dts_value     = dts_out_q;
  assign out_o.error_code    = err_q;
  assign out_o.end_of_packet = eop_q;

endmodule

>>> hw/rtl/php_checker.sv
// Checks on the result channel of the PES header parser, bound to the top level.
module php_checker import php_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [1:0]  result_kind_i,
  input logic [7:0]  payload_out_i,
  input logic [32:0] pts_value_i,
  input logic [32:0] dts_value_i,
  input logic [1:0]  error_code_i,
  input logic        end_of_packet_i
);

  // A stalled result stays and keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(result_kind_i) &&
      $stable(payload_out_i) && $stable(pts_value_i) && $stable(dts_value_i) &&
      $stable(error_code_i) && $stable(end_of_packet_i))
    else $error("result changed while stalled");

  // Only the three defined result kinds are ever shown.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (result_kind_i == KIND_PAYLOAD) || (result_kind_i == KIND_TS) ||
      (result_kind_i == KIND_ERROR))
    else $error("undefined result kind");

  // Payload and error results carry no timestamps.
  a_no_ts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (result_kind_i != KIND_TS) |-> (pts_value_i == '0) && (dts_value_i == '0))
    else $error("timestamp on a non-timestamp result");

  // Timestamp results carry neither a payload byte nor an error code.
  a_ts_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (result_kind_i == KIND_TS) |->
      (payload_out_i == 8'd0) && (error_code_i == ERR_CONTINUITY))
    else $error("stray fields on a timestamp result");

endmodule

bind pes_header_parser_unit php_checker u_php_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (out_o.valid),
  .ready_i         (out_o.ready),
  .result_kind_i   (out_o.result_kind),
  .payload_out_i   (out_o.payload_out),
  .pts_value_i     (out_o.pts_value),
  .dts_value_i     (out_o.dts_value),
  .error_code_i    (out_o.error_code),
  .end_of_packet_i (out_o.end_of_packet)
);
